/* hdl/twss_pkg.sv */
// shared types and constants for the two-ended shared slot store
`timescale 1ns / 1ps
package twss_pkg;

  localparam int PTR_W = 9;
  localparam int HANDLE_W = 32;

  localparam logic [PTR_W-1:0] PTR_MAX = '1;
  localparam logic [PTR_W-1:0] CAP_RESET = 9'd256;

  // item commands
  localparam logic [1:0] CMD_PUSH_LOW = 2'd0;
  localparam logic [1:0] CMD_REMOVE_LOW = 2'd1;
  localparam logic [1:0] CMD_PUSH_HIGH = 2'd2;
  localparam logic [1:0] CMD_REMOVE_HIGH = 2'd3;

  // result status codes
  localparam logic [1:0] STAT_DONE = 2'd0;
  localparam logic [1:0] STAT_FULL = 2'd1;
  localparam logic [1:0] STAT_NOT_FOUND = 2'd2;

  typedef struct packed {
    logic [1:0] cmd;
    logic [HANDLE_W-1:0] handle;
  } in_item_t;

  typedef struct packed {
    logic [1:0] status;
    logic [PTR_W-1:0] low_length;
    logic [PTR_W-1:0] high_length;
  } out_item_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_DECIDE,
    S_SCAN,
    S_FINISH
  } state_t;

  // controller to datapath
  typedef struct packed {
    logic latch;
    logic decide;
    logic scan;
    logic load_out;
  } ctrl_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic is_push;
    logic scan_done;
  } dp_stat_t;

endpackage

/* hdl/two_ended_shared_slot_store.sv */
// top level of the two-ended shared slot store: two handle lists in one slot ram
`timescale 1ns / 1ps
//
// channel   direction  payload                                  handshake
// in_       input      in_item_t  {cmd, handle}                 in_valid / in_ready
// out_      output     out_item_t {status, low_length, high_len} out_valid / out_ready
// cfg_      input      capacity, 9 bits                         cfg_valid / cfg_ready
//
// a push goes from acceptance to result through latch, decide and write, result load
// a remove goes through latch, decide, one read of one slot a cycle for each entry of the
//   addressed list, a last compare when the list is not empty, closing the list, result
//   load; the same pass writes each later entry back one slot toward the base once the
//   match is seen
// one item is in work at a time; the next item is taken while a result waits in the
//   output register, and the block holds in the result stage until that register frees
// synchronous active-low reset: lists empty, capacity min(256, DEPTH); the slot ram
//   itself is not cleared, so there is no clearing pass
// cfg_ready is always high; a capacity write empties both lists
module two_ended_shared_slot_store
  import twss_pkg::*;
#(
  parameter int DEPTH = 256
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_ready,
  input  in_item_t         in_data,
  output logic             out_valid,
  input  logic             out_ready,
  output out_item_t        out_data,
  input  logic             cfg_valid,
  output logic             cfg_ready,
  input  logic [PTR_W-1:0] cfg_data
);

  ctrl_cmd_t ctrl_cmd;
  dp_stat_t  dp_stat;
  logic      cfg_we;

  // capacity writes are always accepted
  assign cfg_ready = 1'b1;
  assign cfg_we = cfg_valid && cfg_ready;

  // sequencing: idle, decide, scan, result load
  twss_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .stat     (dp_stat),
    .cmd      (ctrl_cmd)
  );

  // list pointers, slot ram and the result register
  twss_dp #(
    .DEPTH(DEPTH)
  ) u_dp (
    .clk     (clk),
    .rst_n   (rst_n),
    .cmd     (ctrl_cmd),
    .stat    (dp_stat),
    .in_item (in_data),
    .cfg_we  (cfg_we),
    .cfg_data(cfg_data),
    .out_item(out_data)
  );

`ifndef SYNTHESIS
  // status code three is never produced
  a_status_legal: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_data.status != 2'd3))
    else $error("illegal status on result");

  // once an item is taken the block is busy on the next cycle
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> !in_ready)
    else $error("input taken while an item is in work");

  // the two list lengths together never exceed the pointer range
  a_lengths_fit: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (({1'b0, out_data.low_length} + {1'b0, out_data.high_length})
                   <= {1'b0, PTR_MAX}))
    else $error("list lengths exceed the slot range");
`endif

endmodule

/* hdl/twss_ram.sv */
// generic single-write, single-read ram with registered read data
`timescale 1ns / 1ps
module twss_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rd_data_r <= mem_r[raddr];
    end
  end

  assign rdata = rd_data_r;

endmodule

/* hdl/twss_ctrl.sv */
// controller state machine for the two-ended shared slot store
`timescale 1ns / 1ps
module twss_ctrl
  import twss_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  output logic       out_valid,
  input  logic       out_ready,
  input  dp_stat_t   stat,
  output ctrl_cmd_t  cmd
);

  state_t state_r, state_nxt;
  logic out_valid_r, out_valid_nxt;
  logic out_free;

  assign out_free = !out_valid_r || out_ready;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) state_nxt = S_DECIDE;
      end
      S_DECIDE: begin
        state_nxt = stat.is_push ? S_FINISH : S_SCAN;
      end
      S_SCAN: begin
        if (stat.scan_done) state_nxt = S_FINISH;
      end
      S_FINISH: begin
        if (out_free) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    cmd = '0;
    in_ready = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        cmd.latch = in_valid;
      end
      S_DECIDE: cmd.decide = 1'b1;
      S_SCAN:   cmd.scan = 1'b1;
      S_FINISH: cmd.load_out = out_free;
      default: ;
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.load_out) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid = out_valid_r;

endmodule

/* hdl/twss_dp.sv */
// datapath: list pointers, slot ram, search-and-shift scan, result register
`timescale 1ns / 1ps
module twss_dp
  import twss_pkg::*;
#(
  parameter int DEPTH = 256
) (
  input  logic             clk,
  input  logic             rst_n,
  input  ctrl_cmd_t        cmd,
  output dp_stat_t         stat,
  input  in_item_t         in_item,
  input  logic             cfg_we,
  input  logic [PTR_W-1:0] cfg_data,
  output out_item_t        out_item
);

  localparam int AW = $clog2(DEPTH);
  localparam int CAP_MAX_INT = (DEPTH > int'(PTR_MAX)) ? int'(PTR_MAX) : DEPTH;
  localparam logic [PTR_W-1:0] CAP_MAX = PTR_W'(CAP_MAX_INT);
  localparam logic [PTR_W-1:0] CAP_INIT = (CAP_RESET > CAP_MAX) ? CAP_MAX : CAP_RESET;

  logic [1:0]          op_r, op_nxt;
  logic [HANDLE_W-1:0] handle_r, handle_nxt;
  logic [PTR_W-1:0]    cap_r, cap_nxt;
  logic [PTR_W-1:0]    low_end_r, low_end_nxt;
  logic [PTR_W-1:0]    high_start_r, high_start_nxt;
  logic [PTR_W-1:0]    rd_ptr_r, rd_ptr_nxt;
  logic [PTR_W-1:0]    left_r, left_nxt;
  logic [PTR_W-1:0]    cmp_ptr_r, cmp_ptr_nxt;
  logic                vld_r, vld_nxt;
  logic                found_r, found_nxt;
  logic [1:0]          stat_r, stat_nxt;
  out_item_t           out_r, out_nxt;

  logic                is_high, is_push, full, scan_done;
  logic [PTR_W-1:0]    len, cap_clamped;
  logic                we, re;
  logic [AW-1:0]       waddr, raddr;
  logic [HANDLE_W-1:0] wdata, rdata;

  assign is_high = (op_r == CMD_PUSH_HIGH) || (op_r == CMD_REMOVE_HIGH);
  assign is_push = (op_r == CMD_PUSH_LOW) || (op_r == CMD_PUSH_HIGH);
  assign len = is_high ? (cap_r - high_start_r) : low_end_r;
  assign full = low_end_r >= high_start_r;
  assign scan_done = (left_r == '0) && !vld_r;
  assign cap_clamped = (cfg_data > CAP_MAX) ? CAP_MAX : cfg_data;

  assign stat.is_push = is_push;
  assign stat.scan_done = scan_done;

  always_comb begin
    op_nxt = op_r;
    handle_nxt = handle_r;
    cap_nxt = cap_r;
    low_end_nxt = low_end_r;
    high_start_nxt = high_start_r;
    rd_ptr_nxt = rd_ptr_r;
    left_nxt = left_r;
    cmp_ptr_nxt = cmp_ptr_r;
    vld_nxt = vld_r;
    found_nxt = found_r;
    stat_nxt = stat_r;
    we = 1'b0;
    waddr = '0;
    wdata = handle_r;
    re = 1'b0;
    raddr = '0;

    if (cfg_we) begin
      cap_nxt = cap_clamped;
      low_end_nxt = '0;
      high_start_nxt = cap_clamped;
    end else if (cmd.latch) begin
      op_nxt = in_item.cmd;
      handle_nxt = in_item.handle;
    end else if (cmd.decide) begin
      found_nxt = 1'b0;
      vld_nxt = 1'b0;
      if (is_push) begin
        if (full) begin
          stat_nxt = STAT_FULL;
        end else begin
          stat_nxt = STAT_DONE;
          we = 1'b1;
          if (is_high) begin
            high_start_nxt = high_start_r - 1'b1;
            waddr = AW'(high_start_r - 1'b1);
          end else begin
            low_end_nxt = low_end_r + 1'b1;
            waddr = AW'(low_end_r);
          end
        end
      end else begin
        rd_ptr_nxt = is_high ? (cap_r - 1'b1) : '0;
        left_nxt = len;
      end
    end else if (cmd.scan) begin
      // issue one read a cycle, walking away from the list base
      vld_nxt = 1'b0;
      if (left_r != '0) begin
        re = 1'b1;
        raddr = AW'(rd_ptr_r);
        rd_ptr_nxt = is_high ? (rd_ptr_r - 1'b1) : (rd_ptr_r + 1'b1);
        left_nxt = left_r - 1'b1;
        cmp_ptr_nxt = rd_ptr_r;
        vld_nxt = 1'b1;
      end
      // returning slot: match first, then pull later entries toward the base
      if (vld_r) begin
        if (found_r) begin
          we = 1'b1;
          wdata = rdata;
          waddr = is_high ? AW'(cmp_ptr_r + 1'b1) : AW'(cmp_ptr_r - 1'b1);
        end else if (rdata == handle_r) begin
          found_nxt = 1'b1;
        end
      end
      if (scan_done) begin
        if (found_r) begin
          stat_nxt = STAT_DONE;
          if (is_high) high_start_nxt = high_start_r + 1'b1;
          else low_end_nxt = low_end_r - 1'b1;
        end else begin
          stat_nxt = STAT_NOT_FOUND;
        end
      end
    end
  end

  always_comb begin
    out_nxt = out_r;
    if (cmd.load_out) begin
      out_nxt.status = stat_r;
      out_nxt.low_length = low_end_r;
      out_nxt.high_length = cap_r - high_start_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cap_r <= CAP_INIT;
      low_end_r <= '0;
      high_start_r <= CAP_INIT;
      left_r <= '0;
      vld_r <= 1'b0;
      found_r <= 1'b0;
    end else begin
      cap_r <= cap_nxt;
      low_end_r <= low_end_nxt;
      high_start_r <= high_start_nxt;
      left_r <= left_nxt;
      vld_r <= vld_nxt;
      found_r <= found_nxt;
    end
  end

  always_ff @(posedge clk) begin
    op_r <= op_nxt;
    handle_r <= handle_nxt;
    rd_ptr_r <= rd_ptr_nxt;
    cmp_ptr_r <= cmp_ptr_nxt;
    stat_r <= stat_nxt;
    out_r <= out_nxt;
  end

  twss_ram #(
    .WIDTH(HANDLE_W),
    .DEPTH(DEPTH)
  ) u_ram (
    .clk  (clk),
    .we   (we),
    .waddr(waddr),
    .wdata(wdata),
    .re   (re),
    .raddr(raddr),
    .rdata(rdata)
  );

  assign out_item = out_r;

endmodule

/* sim/testbench.sv */
// self-checking testbench for the two-ended shared slot store
`timescale 1ns / 1ps
module testbench;
  import twss_pkg::*;

  localparam int SLOT_COUNT = 256;
  localparam int HOLD_CYCLES = 300;
  localparam int STALL_LIMIT = 20000;
  localparam int SETTLE_CYCLES = 20;

  typedef enum int {
    IDLE_NONE,
    IDLE_SENDER,
    IDLE_RECEIVER,
    IDLE_BOTH
  } idle_mode_t;

  // one row of the directed table: a capacity write or an item,
  // optionally with its result typed in by hand
  typedef struct {
    bit        is_cap_write;
    logic [PTR_W-1:0] cap;
    in_item_t  item;
    bit        typed;
    out_item_t want;
  } stim_row_t;

  logic             clk;
  logic             rst_n;
  logic             in_valid;
  logic             in_ready;
  in_item_t         in_data;
  logic             out_valid;
  logic             out_ready;
  out_item_t        out_data;
  logic             cfg_valid;
  logic             cfg_ready;
  logic [PTR_W-1:0] cfg_data;

  // shadow copy of the store
  logic [HANDLE_W-1:0] shadow_slots [SLOT_COUNT];
  int shadow_cap;
  int shadow_low_end;
  int shadow_high_start;

  out_item_t expected_results [$];
  stim_row_t directed_rows [$];

  bit        row_typed_now;
  out_item_t row_want_now;
  int        send_idle_pct;
  int        recv_stall_pct;
  int        hold_requests;
  int        mismatches;
  int        quiet_cycles;

  two_ended_shared_slot_store #(
    .DEPTH(SLOT_COUNT)
  ) DUT (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_data (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  task automatic report_mismatch(input string what, input int got_v, input int want_v);
    $display("mismatch at %0t: %s got %0d expected %0d", $time, what, got_v, want_v);
    mismatches++;
  endtask

  // applies one item to the shadow store and returns the result it gives
  function automatic out_item_t store_apply(input in_item_t it);
    out_item_t r;
    logic [1:0] st;
    int hit;
    int i;
    st = STAT_NOT_FOUND;
    hit = -1;
    case (it.cmd)
      CMD_PUSH_LOW: begin
        if (shadow_low_end >= shadow_high_start) begin
          st = STAT_FULL;
        end else begin
          shadow_slots[shadow_low_end] = it.handle;
          shadow_low_end++;
          st = STAT_DONE;
        end
      end
      CMD_PUSH_HIGH: begin
        if (shadow_high_start <= shadow_low_end) begin
          st = STAT_FULL;
        end else begin
          shadow_high_start--;
          shadow_slots[shadow_high_start] = it.handle;
          st = STAT_DONE;
        end
      end
      CMD_REMOVE_LOW: begin
        // search upward from slot 0, then close the gap toward the base
        for (i = 0; i < shadow_low_end && hit < 0; i++)
          if (shadow_slots[i] == it.handle) hit = i;
        if (hit >= 0) begin
          for (i = hit; i + 1 < shadow_low_end; i++) shadow_slots[i] = shadow_slots[i + 1];
          shadow_low_end--;
          st = STAT_DONE;
        end
      end
      default: begin
        // high list base is the top slot, search downward from there
        for (i = shadow_cap - 1; i >= shadow_high_start && hit < 0; i--)
          if (shadow_slots[i] == it.handle) hit = i;
        if (hit >= 0) begin
          for (i = hit; i > shadow_high_start; i--) shadow_slots[i] = shadow_slots[i - 1];
          shadow_high_start++;
          st = STAT_DONE;
        end
      end
    endcase
    r.status = st;
    r.low_length = PTR_W'(shadow_low_end);
    r.high_length = PTR_W'(shadow_cap - shadow_high_start);
    return r;
  endfunction

  // sample every handshake at the rising edge: check results, predict items, track capacity
  always @(posedge clk) begin : sample_ports
    out_item_t got;
    out_item_t want;
    int c;
    if (rst_n) begin
      if (out_valid && out_ready) begin
        got = out_data;
        if (expected_results.size() == 0) begin
          report_mismatch("status of unexpected result", int'(got.status), -1);
        end else begin
          want = expected_results.pop_front();
          if (got.status !== want.status)
            report_mismatch("status", int'(got.status), int'(want.status));
          if (got.low_length !== want.low_length)
            report_mismatch("low_length", int'(got.low_length), int'(want.low_length));
          if (got.high_length !== want.high_length)
            report_mismatch("high_length", int'(got.high_length), int'(want.high_length));
        end
      end
      if (in_valid && in_ready) begin
        want = store_apply(in_data);
        if (row_typed_now) want = row_want_now;
        expected_results.push_back(want);
      end
      if (cfg_valid && cfg_ready) begin
        // capacity saturates at the slot count; a write empties both lists
        c = int'(cfg_data);
        if (c > SLOT_COUNT) c = SLOT_COUNT;
        shadow_cap = c;
        shadow_low_end = 0;
        shadow_high_start = c;
      end
    end
  end

  // ends the run when nothing moves for too long
  always @(posedge clk) begin
    if (!rst_n) begin
      quiet_cycles <= 0;
    end else begin
      if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready)) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles >= STALL_LIMIT) begin
        $display("Testbench completed WITH ERRORS");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

  // result side: random stalls, plus a long hold-off on request
  initial begin : receiver
    int hold_left;
    int served;
    hold_left = 0;
    served = 0;
    out_ready = 1'b0;
    forever begin
      @(negedge clk);
      if (served != hold_requests) begin
        served = hold_requests;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        out_ready = 1'b0;
        hold_left--;
      end else begin
        out_ready = ($urandom_range(99) >= recv_stall_pct);
      end
    end
  end

  task automatic set_idling(input idle_mode_t mode);
    case (mode)
      IDLE_SENDER: begin
        send_idle_pct = 87;
        recv_stall_pct = 0;
      end
      IDLE_RECEIVER: begin
        send_idle_pct = 0;
        recv_stall_pct = 87;
      end
      IDLE_BOTH: begin
        send_idle_pct = 35;
        recv_stall_pct = 35;
      end
      default: begin
        send_idle_pct = 0;
        recv_stall_pct = 0;
      end
    endcase
  endtask

  // called and returns at a falling edge with in_valid low
  task automatic send_item(input in_item_t it);
    while ($urandom_range(99) < send_idle_pct) @(negedge clk);
    in_valid = 1'b1;
    in_data = it;
    do @(posedge clk); while (!in_ready);
    @(negedge clk);
    in_valid = 1'b0;
  endtask

  task automatic write_capacity(input logic [PTR_W-1:0] value);
    cfg_valid = 1'b1;
    cfg_data = value;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  // wait for every outstanding result
  task automatic drain_results();
    while (expected_results.size() != 0) @(negedge clk);
  endtask

  function automatic logic [HANDLE_W-1:0] pick_entry(input bit high_side);
    if (high_side) return shadow_slots[$urandom_range(shadow_cap - 1, shadow_high_start)];
    return shadow_slots[$urandom_range(shadow_low_end - 1)];
  endfunction

  // removes mostly name handles that are present, so matches and shifts happen often
  function automatic in_item_t next_random_item(input int push_pct);
    in_item_t it;
    bit high_side;
    int own_len;
    int other_len;
    int roll;
    high_side = 1'($urandom_range(1));
    own_len = high_side ? shadow_cap - shadow_high_start : shadow_low_end;
    other_len = high_side ? shadow_low_end : shadow_cap - shadow_high_start;
    roll = $urandom_range(99);
    if ($urandom_range(99) < push_pct) begin
      it.cmd = high_side ? CMD_PUSH_HIGH : CMD_PUSH_LOW;
      // small handles give plenty of duplicates
      it.handle = (roll < 40) ? HANDLE_W'($urandom_range(7)) : $urandom;
    end else begin
      it.cmd = high_side ? CMD_REMOVE_HIGH : CMD_REMOVE_LOW;
      if (own_len > 0 && roll < 70) it.handle = pick_entry(high_side);
      else if (other_len > 0 && roll < 80) it.handle = pick_entry(!high_side);
      else if (roll < 90) it.handle = HANDLE_W'($urandom_range(7));
      else it.handle = $urandom;
    end
    return it;
  endfunction

  task automatic run_phase(input int cap, input idle_mode_t mode, input int count,
                           input int push_pct, input bit hold_off);
    int n;
    drain_results();
    write_capacity(PTR_W'(cap));
    set_idling(mode);
    row_typed_now = 1'b0;
    // receiver stalls for a long stretch while items keep coming
    if (hold_off) hold_requests++;
    for (n = 0; n < count; n++) begin
      // sender pauses mid-phase until the block has emptied
      if (n == count / 2) drain_results();
      send_item(next_random_item(push_pct));
    end
    drain_results();
  endtask

  function automatic stim_row_t op_row(input logic [1:0] cmd, input logic [HANDLE_W-1:0] h);
    stim_row_t r;
    r.is_cap_write = 1'b0;
    r.cap = '0;
    r.item.cmd = cmd;
    r.item.handle = h;
    r.typed = 1'b0;
    r.want = '0;
    return r;
  endfunction

  function automatic stim_row_t checked_row(input logic [1:0] cmd,
                                            input logic [HANDLE_W-1:0] h,
                                            input logic [1:0] st, input int lo, input int hi);
    stim_row_t r;
    r = op_row(cmd, h);
    r.typed = 1'b1;
    r.want.status = st;
    r.want.low_length = PTR_W'(lo);
    r.want.high_length = PTR_W'(hi);
    return r;
  endfunction

  function automatic stim_row_t cap_row(input logic [PTR_W-1:0] c);
    stim_row_t r;
    r = op_row(CMD_PUSH_LOW, '0);
    r.is_cap_write = 1'b1;
    r.cap = c;
    return r;
  endfunction

  initial begin : stimulus
    int i;
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_data = '0;
    cfg_valid = 1'b0;
    cfg_data = '0;
    row_typed_now = 1'b0;
    row_want_now = '0;
    hold_requests = 0;
    mismatches = 0;
    set_idling(IDLE_NONE);
    for (i = 0; i < SLOT_COUNT; i++) shadow_slots[i] = '0;
    shadow_cap = SLOT_COUNT;
    shadow_low_end = 0;
    shadow_high_start = SLOT_COUNT;

    // empty store at reset capacity
    directed_rows.push_back(checked_row(CMD_REMOVE_LOW, 32'h1234_5678, STAT_NOT_FOUND, 0, 0));
    directed_rows.push_back(checked_row(CMD_REMOVE_HIGH, 32'hFFFF_FFFF, STAT_NOT_FOUND, 0, 0));
    directed_rows.push_back(checked_row(CMD_PUSH_LOW, 32'h0000_0000, STAT_DONE, 1, 0));
    directed_rows.push_back(checked_row(CMD_PUSH_LOW, 32'hFFFF_FFFF, STAT_DONE, 2, 0));
    directed_rows.push_back(checked_row(CMD_PUSH_HIGH, 32'hFFFF_FFFF, STAT_DONE, 2, 1));
    directed_rows.push_back(checked_row(CMD_PUSH_HIGH, 32'h0000_0000, STAT_DONE, 2, 2));
    // duplicates in the low list: only the one nearest slot 0 goes
    directed_rows.push_back(op_row(CMD_PUSH_LOW, 32'hA5A5_A5A5));
    directed_rows.push_back(op_row(CMD_PUSH_LOW, 32'h0000_0000));
    directed_rows.push_back(op_row(CMD_REMOVE_LOW, 32'h0000_0000));
    directed_rows.push_back(op_row(CMD_REMOVE_LOW, 32'h0000_0000));
    directed_rows.push_back(checked_row(CMD_REMOVE_LOW, 32'h0000_0000, STAT_NOT_FOUND, 2, 2));
    // high list: remove at its base shifts the rest toward the base
    directed_rows.push_back(op_row(CMD_PUSH_HIGH, 32'h0000_FFFF));
    directed_rows.push_back(op_row(CMD_REMOVE_HIGH, 32'hFFFF_FFFF));
    directed_rows.push_back(op_row(CMD_REMOVE_HIGH, 32'h0000_0000));
    // zero capacity: always full, never found
    directed_rows.push_back(cap_row(9'd0));
    directed_rows.push_back(checked_row(CMD_PUSH_LOW, 32'h0000_0001, STAT_FULL, 0, 0));
    directed_rows.push_back(checked_row(CMD_PUSH_HIGH, 32'h0000_0002, STAT_FULL, 0, 0));
    directed_rows.push_back(checked_row(CMD_REMOVE_LOW, 32'h0000_0001, STAT_NOT_FOUND, 0, 0));
    directed_rows.push_back(checked_row(CMD_REMOVE_HIGH, 32'h0000_0002, STAT_NOT_FOUND, 0, 0));
    // two slots: the lists meet after one push each
    directed_rows.push_back(cap_row(9'd2));
    directed_rows.push_back(checked_row(CMD_PUSH_HIGH, 32'hDEAD_BEEF, STAT_DONE, 0, 1));
    directed_rows.push_back(checked_row(CMD_PUSH_LOW, 32'h5555_5555, STAT_DONE, 1, 1));
    directed_rows.push_back(checked_row(CMD_PUSH_LOW, 32'h0000_0007, STAT_FULL, 1, 1));
    directed_rows.push_back(checked_row(CMD_PUSH_HIGH, 32'h0000_0008, STAT_FULL, 1, 1));
    directed_rows.push_back(op_row(CMD_REMOVE_HIGH, 32'hDEAD_BEEF));
    // capacity above the slot count saturates
    directed_rows.push_back(cap_row(9'h1FF));
    directed_rows.push_back(checked_row(CMD_PUSH_HIGH, 32'h8000_0001, STAT_DONE, 0, 1));
    // single slot
    directed_rows.push_back(cap_row(9'd1));
    directed_rows.push_back(checked_row(CMD_PUSH_LOW, 32'hC0FF_EE00, STAT_DONE, 1, 0));
    directed_rows.push_back(checked_row(CMD_PUSH_HIGH, 32'h0000_0001, STAT_FULL, 1, 0));

    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    set_idling(IDLE_BOTH);
    foreach (directed_rows[i]) begin
      if (directed_rows[i].is_cap_write) begin
        drain_results();
        write_capacity(directed_rows[i].cap);
      end else begin
        row_typed_now = directed_rows[i].typed;
        row_want_now = directed_rows[i].want;
        send_item(directed_rows[i].item);
      end
    end
    row_typed_now = 1'b0;

    run_phase(16, IDLE_NONE, 230, 55, 1'b0);
    run_phase(16, IDLE_SENDER, 150, 55, 1'b0);
    run_phase(40, IDLE_RECEIVER, 150, 55, 1'b0);
    run_phase(8, IDLE_BOTH, 150, 50, 1'b0);
    run_phase(3, IDLE_NONE, 100, 50, 1'b1);
    run_phase(256, IDLE_BOTH, 120, 65, 1'b0);
    run_phase(100, IDLE_RECEIVER, 150, 60, 1'b0);
    run_phase(300, IDLE_SENDER, 100, 60, 1'b0);
    run_phase(1, IDLE_BOTH, 20, 50, 1'b0);

    // let any stray result show up before the verdict
    drain_results();
    set_idling(IDLE_NONE);
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (mismatches == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
